// ===== design/sha224c_pkg.sv =====
package sha224c_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned Rounds = 64;

  typedef logic [WordW-1:0] word_t;
  typedef logic [3:0]       sched_addr_t;
  typedef logic [2:0]       chain_addr_t;
  typedef logic [5:0]       round_t;

  localparam word_t INIT_HASH [8] = '{
    32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
    32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
  };

  localparam word_t ROUND_K [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // schedule memory port request
  typedef struct packed {
    logic        we;
    sched_addr_t wa;
    word_t       wd;
    logic        re;
    sched_addr_t ra0;
    sched_addr_t ra1;
  } sched_req_t;

  // chaining value memory port request
  typedef struct packed {
    logic        clr;
    logic        we;
    chain_addr_t wa;
    word_t       wd;
    logic        re;
    chain_addr_t ra;
  } chain_req_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t big_sig0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sig1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sig0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sig1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t choose(input word_t e, input word_t f, input word_t g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic word_t majority(input word_t a, input word_t b, input word_t c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

// ===== design/sha224c_ifs.sv =====
interface sha224c_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] msg_word;
  logic        first_block;
  logic        last_block;

  modport source (output valid, output msg_word, output first_block, output last_block,
                  input ready);
  modport sink   (input valid, input msg_word, input first_block, input last_block,
                  output ready);
endinterface

interface sha224c_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        digest_last;

  modport source (output valid, output digest_word, output digest_last, input ready);
  modport sink   (input valid, input digest_word, input digest_last, output ready);
endinterface

// ===== design/sha224c_sched.sv =====
module sha224c_sched
  import sha224c_pkg::*;
(
  input  logic       clk,
  input  sched_req_t req,
  output word_t      q0,
  output word_t      q1
);

  word_t mem [16];
  word_t q0_r;
  word_t q1_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.wa] <= req.wd;
    end
    if (req.re) begin
      q0_r <= mem[req.ra0];
      q1_r <= mem[req.ra1];
    end
  end

  assign q0 = q0_r;
  assign q1 = q1_r;

endmodule

// ===== design/sha224c_chain.sv =====
module sha224c_chain
  import sha224c_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  chain_req_t req,
  output word_t      dout
);

  word_t       mem [8];
  logic [7:0]  vld_r;
  word_t       q_r;
  logic        qv_r;
  chain_addr_t qa_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.clr) begin
      vld_r <= '0;
    end else if (req.we) begin
      vld_r[req.wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.wa] <= req.wd;
    end
    if (req.re) begin
      q_r  <= mem[req.ra];
      qv_r <= vld_r[req.ra];
      qa_r <= req.ra;
    end
  end

  // an entry not yet written since reset or a first block holds the initial hash
  assign dout = qv_r ? q_r : INIT_HASH[qa_r];

endmodule

// ===== design/sha224c_top.sv =====
// Channel   Dir  Payload                              Handshake
// in_chan   in   msg_word[31:0] first_block last_block valid/ready
// out_chan  out  digest_word[31:0] digest_last        valid/ready
//
// The first 15 words of a block are written into the schedule memory. The 16th
// word starts compression: the working variables are loaded from the chaining-
// value memory, each round passes through S_RA and S_RC, and rounds 16-63 also
// through S_RB (the schedule memory has two read ports and expansion needs four
// words), then each word is added back into the chaining value (S_UA, S_UB).
// Reset (synchronous, rst_n low) restores the initial hash and the word count.
// A stalled digest word holds the chain update; input is taken again once the
// eighth chaining word has been written back, after the last digest word.
module sha224_compression_core_top
  import sha224c_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  sha224c_in_if.sink     in_chan,
  sha224c_out_if.source  out_chan
);

  typedef enum logic [2:0] {
    S_IDLE, S_LD, S_RA, S_RB, S_RC, S_UA, S_UB
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] wcnt_r, wcnt_nxt;
  logic       last_r, last_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  round_t     rnd_r, rnd_nxt;
  word_t      v_r [8];
  word_t      v_nxt [8];
  word_t      p_r, p_nxt;
  logic       out_valid_r, out_valid_nxt;
  word_t      out_word_r, out_word_nxt;
  logic       out_last_r, out_last_nxt;

  sched_req_t sreq;
  chain_req_t creq;
  word_t      sq0, sq1, cdout;

  logic  acc, out_free, early, need_out;
  word_t wt, t1, t2, sum;

  sha224c_sched u_sched (
    .clk (clk),
    .req (sreq),
    .q0  (sq0),
    .q1  (sq1)
  );

  sha224c_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (creq),
    .dout  (cdout)
  );

  assign in_chan.ready        = (state_r == S_IDLE);
  assign acc                  = in_chan.valid && in_chan.ready;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.digest_word = out_word_r;
  assign out_chan.digest_last = out_last_r;
  assign out_free             = !out_valid_r || out_chan.ready;

  assign early    = (rnd_r[5:4] == 2'b00);
  assign wt       = early ? sq0 : p_r + sq0 + sq1;
  assign t1       = v_r[7] + big_sig1(v_r[4]) + choose(v_r[4], v_r[5], v_r[6])
                    + ROUND_K[rnd_r] + wt;
  assign t2       = big_sig0(v_r[0]) + majority(v_r[0], v_r[1], v_r[2]);
  assign sum      = cdout + v_r[cnt_r[2:0]];
  assign need_out = last_r && (cnt_r != 4'd7);

  always_comb begin
    state_nxt     = state_r;
    wcnt_nxt      = wcnt_r;
    last_nxt      = last_r;
    cnt_nxt       = cnt_r;
    rnd_nxt       = rnd_r;
    v_nxt         = v_r;
    p_nxt         = p_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_word_nxt  = out_word_r;
    out_last_nxt  = out_last_r;
    sreq          = '0;
    creq          = '0;

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          sreq.we  = 1'b1;
          sreq.wa  = wcnt_r;
          sreq.wd  = in_chan.msg_word;
          creq.clr = (wcnt_r == 4'd0) && in_chan.first_block;
          wcnt_nxt = wcnt_r + 4'd1;
          if (wcnt_r == 4'd15) begin
            last_nxt  = in_chan.last_block;
            cnt_nxt   = 4'd0;
            state_nxt = S_LD;
          end
        end
      end
      S_LD: begin
        // read one chain word a cycle, capture it the cycle after
        if (!cnt_r[3]) begin
          creq.re = 1'b1;
          creq.ra = cnt_r[2:0];
        end
        if (cnt_r != 4'd0) begin
          v_nxt[cnt_r[2:0] - 3'd1] = cdout;
        end
        if (cnt_r == 4'd8) begin
          rnd_nxt   = '0;
          state_nxt = S_RA;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      S_RA: begin
        sreq.re = 1'b1;
        if (early) begin
          sreq.ra0  = rnd_r[3:0];
          state_nxt = S_RC;
        end else begin
          sreq.ra0  = rnd_r[3:0] - 4'd2;
          sreq.ra1  = rnd_r[3:0] - 4'd15;
          state_nxt = S_RB;
        end
      end
      S_RB: begin
        p_nxt     = small_sig1(sq0) + small_sig0(sq1);
        sreq.re   = 1'b1;
        sreq.ra0  = rnd_r[3:0] - 4'd7;
        sreq.ra1  = rnd_r[3:0];
        state_nxt = S_RC;
      end
      S_RC: begin
        // write back the expanded word; the next round reads only after this edge
        if (!early) begin
          sreq.we = 1'b1;
          sreq.wa = rnd_r[3:0];
          sreq.wd = wt;
        end
        v_nxt[7] = v_r[6];
        v_nxt[6] = v_r[5];
        v_nxt[5] = v_r[4];
        v_nxt[4] = v_r[3] + t1;
        v_nxt[3] = v_r[2];
        v_nxt[2] = v_r[1];
        v_nxt[1] = v_r[0];
        v_nxt[0] = t1 + t2;
        if (rnd_r == 6'd63) begin
          cnt_nxt   = 4'd0;
          state_nxt = S_UA;
        end else begin
          rnd_nxt   = rnd_r + 6'd1;
          state_nxt = S_RA;
        end
      end
      S_UA: begin
        creq.re   = 1'b1;
        creq.ra   = cnt_r[2:0];
        state_nxt = S_UB;
      end
      S_UB: begin
        // hold while a digest word is due and the output register is still occupied
        if (!need_out || out_free) begin
          creq.we = 1'b1;
          creq.wa = cnt_r[2:0];
          creq.wd = sum;
          if (need_out) begin
            out_valid_nxt = 1'b1;
            out_word_nxt  = sum;
            out_last_nxt  = (cnt_r == 4'd6);
          end
          if (cnt_r == 4'd7) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt   = cnt_r + 4'd1;
            state_nxt = S_UA;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wcnt_r      <= '0;
      last_r      <= 1'b0;
      cnt_r       <= '0;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wcnt_r      <= wcnt_nxt;
      last_r      <= last_nxt;
      cnt_r       <= cnt_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
    v_r          <= v_nxt;
    p_r          <= p_nxt;
    out_word_r   <= out_word_nxt;
    out_last_r   <= out_last_nxt;
  end

  a_block_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && wcnt_r == 4'd15) |=> (state_r == S_LD && cnt_r == 4'd0))
    else $error("16th word did not start compression");

  a_rounds_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RC && rnd_r == 6'd63) |=> (state_r == S_UA && cnt_r == 4'd0))
    else $error("last round did not start the chain update");

  a_digest_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r == S_UB) && $past(last_r)))
    else $error("digest word raised outside the chain update of a last block");

  a_sched_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
    sreq.we |-> !sreq.re)
    else $error("schedule write overlaps a read");

endmodule

// ===== verif/sha224_digest_checker.sv =====
`timescale 1ns / 100ps

module sha224_digest_checker
  import sha224c_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  word_t       in_msg_word,
  input  logic        in_first_block,
  input  logic        in_last_block,
  input  logic        out_valid,
  input  logic        out_ready,
  input  word_t       out_digest_word,
  input  logic        out_digest_last,
  output int unsigned mismatches,
  output int unsigned pending
);

  typedef struct packed {
    word_t word;
    logic  last;
  } digest_t;

  localparam word_t IV224 [8] = '{
    32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
    32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
  };

  localparam word_t K256 [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  word_t      chain_h [8];
  word_t      sched_w [16];
  logic [3:0] word_idx;
  digest_t    digest_q [$];

  function automatic word_t ror32(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // 64 rounds over the buffered block, folded into the chaining value
  function automatic void run_rounds();
    word_t w [16];
    word_t v [8];
    word_t wt, t1, t2, x2, x15;
    int    t;
    w = sched_w;
    v = chain_h;
    for (t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        x2  = w[(t + 14) % 16];
        x15 = w[(t + 1) % 16];
        wt = (ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10)) + w[(t + 9) % 16]
           + (ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3)) + w[t % 16];
        w[t % 16] = wt;
      end
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K256[t] + wt;
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (t = 0; t < 8; t++) chain_h[t] = chain_h[t] + v[t];
  endfunction

  always @(posedge clk) begin
    digest_t exp_d;
    if (!rst_n) begin
      chain_h    = IV224;
      word_idx   = '0;
      mismatches = 0;
      digest_q.delete();
    end else begin
      // check the result before predicting, so a request never matches its own edge
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          $display("%0t: digest word %h (last %b) with nothing expected",
                   $time, out_digest_word, out_digest_last);
          mismatches++;
        end else begin
          exp_d = digest_q.pop_front();
          if (out_digest_word !== exp_d.word) begin
            $display("%0t: digest_word expected %h, got %h",
                     $time, exp_d.word, out_digest_word);
            mismatches++;
          end
          if (out_digest_last !== exp_d.last) begin
            $display("%0t: digest_last expected %b, got %b",
                     $time, exp_d.last, out_digest_last);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        // flags count only on the first and sixteenth word of a block
        if (word_idx == 4'd0 && in_first_block) chain_h = IV224;
        sched_w[word_idx] = in_msg_word;
        if (word_idx == 4'd15) begin
          run_rounds();
          if (in_last_block) begin
            for (int k = 0; k < 7; k++) begin
              digest_q.insert(digest_q.size(), digest_t'{chain_h[k], k == 6});
            end
          end
        end
        word_idx = word_idx + 4'd1;
      end
    end
    pending = digest_q.size();
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench
  import sha224c_pkg::*;
();

  localparam int unsigned ClkPeriod   = 4;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned TotalWords  = 432;
  localparam int unsigned DrainCycles = 300;

  logic        clk;
  logic        rst_n;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned cycle_cnt;
  int unsigned stall_left;
  int unsigned words_sent;
  bit          quiet;

  sha224c_in_if  in_chan ();
  sha224c_out_if out_chan ();

  sha224_compression_core_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  sha224_digest_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_chan.valid),
    .in_ready        (in_chan.ready),
    .in_msg_word     (in_chan.msg_word),
    .in_first_block  (in_chan.first_block),
    .in_last_block   (in_chan.last_block),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_digest_word (out_chan.digest_word),
    .out_digest_last (out_chan.digest_last),
    .mismatches      (mismatches),
    .pending         (pending)
  );

  initial clk = 1'b0;
  always #(ClkPeriod / 2) clk = ~clk;

  // mostly no wait, some short ones, a few long ones
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic word_t msg_value();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  task automatic send_word(input word_t w, input logic f, input logic l);
    int unsigned gap;
    gap = idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.msg_word    <= w;
    in_chan.first_block <= f;
    in_chan.last_block  <= l;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    words_sent++;
  endtask

  // stray flags on the middle words must be ignored
  task automatic send_block(input logic first, input logic last);
    logic f, l;
    for (int i = 0; i < 16; i++) begin
      f = (i == 0) ? first : ($urandom_range(3) == 0);
      l = (i == 15) ? last : ($urandom_range(3) == 0);
      send_word(msg_value(), f, l);
    end
  endtask

  // stall the digest side at random
  always @(negedge clk) begin
    if (stall_left > 0) stall_left--;
    else stall_left = idle_len();
    out_chan.ready <= (stall_left == 0);
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    int unsigned nblk;
    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.msg_word    = '0;
    in_chan.first_block = 1'b0;
    in_chan.last_block  = 1'b0;
    out_chan.ready      = 1'b0;
    quiet               = 1'b0;
    stall_left          = 0;
    words_sent          = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // alternating all-zero and all-one words, flags also on wrong words
    for (int i = 0; i < 16; i++) begin
      send_word(i[0] ? 32'hffffffff : 32'h00000000, i == 0 || i == 6, i == 4 || i == 15);
    end
    // no first_block: continue from the digest just emitted
    for (int i = 0; i < 16; i++) begin
      send_word(i == 0 ? 32'h80000000 : 32'h00000001 << (2 * i), i == 9, i == 15);
    end

    while (words_sent < TotalWords) begin
      quiet = ($urandom_range(4) == 0);
      nblk  = $urandom_range(3, 1);
      for (int b = 0; b < nblk; b++) begin
        send_block(b == 0 ? ($urandom_range(9) != 0) : ($urandom_range(7) == 0),
                   b == nblk - 1 ? ($urandom_range(9) != 0) : ($urandom_range(7) == 0));
      end
    end
    quiet = 1'b0;

    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    // let a trailing compression finish to catch stray results
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
